[hdl/hcidf_pkg.sv]
// Package with the shared types and constants of the HCI UART packet deframer.
package hcidf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [ByteW-1:0]  IndEvent       = 8'h04;
  localparam logic [ByteW-1:0]  IndAcl         = 8'h02;
  localparam logic [CountW-1:0] AclLimitReset  = 16'd1020;
  localparam logic              RegIdxAclLimit = 1'b0;

  localparam logic KindEvent = 1'b0;
  localparam logic KindAcl   = 1'b1;

  typedef enum logic [2:0] {
    PhIdle,
    PhEvCode,
    PhEvLen,
    PhEvParam,
    PhAclHandle,
    PhAclLen,
    PhAclData
  } rx_phase_e;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  data;
    logic              kind;
    logic [CountW-1:0] index;
    logic              eop;
    logic              aborted;
  } hcidf_result_t;

endpackage

[hdl/hcidf_parser.sv]
// Packet phase tracker that turns one byte into at most one tagged packet byte.
module hcidf_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [hcidf_pkg::ByteW-1:0]   byte_i,
  input  logic [hcidf_pkg::CountW-1:0]  limit_i,
  output hcidf_pkg::hcidf_result_t      result_o
);
  import hcidf_pkg::*;

  rx_phase_e         phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [ByteW-1:0]  len_low_q, len_low_d;
  logic              high_next_q, high_next_d;

  logic [CountW-1:0] remain_dec;
  logic [CountW-1:0] acl_len;
  hcidf_result_t     res;

  assign remain_dec = remain_q - CountW'(1);
  assign acl_len    = {byte_i, len_low_q};

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    remain_d    = remain_q;
    len_low_d   = len_low_q;
    high_next_d = high_next_q;
    res.valid   = 1'b0;
    res.data    = byte_i;
    res.kind    = KindEvent;
    res.index   = count_q;
    res.eop     = 1'b0;
    res.aborted = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (byte_i == IndEvent) begin
          count_d = '0;
          phase_d = PhEvCode;
        end else if (byte_i == IndAcl) begin
          count_d     = '0;
          high_next_d = 1'b0;
          phase_d     = PhAclHandle;
        end
      end
      PhEvCode: begin
        res.valid = 1'b1;
        phase_d   = PhEvLen;
      end
      PhEvLen: begin
        res.valid = 1'b1;
        if (byte_i != '0) begin
          remain_d = CountW'(byte_i);
          phase_d  = PhEvParam;
        end else begin
          res.eop = 1'b1;
          phase_d = PhIdle;
        end
      end
      PhEvParam: begin
        res.valid = 1'b1;
        remain_d  = remain_dec;
        if (remain_dec == '0) begin
          res.eop = 1'b1;
          phase_d = PhIdle;
        end
      end
      PhAclHandle: begin
        res.valid = 1'b1;
        res.kind  = KindAcl;
        if (count_q != '0) begin
          phase_d = PhAclLen;
        end
      end
      PhAclLen: begin
        res.valid = 1'b1;
        res.kind  = KindAcl;
        if (!high_next_q) begin
          len_low_d   = byte_i;
          high_next_d = 1'b1;
        end else begin
          high_next_d = 1'b0;
          if (acl_len > limit_i) begin
            res.aborted = 1'b1;
            phase_d     = PhIdle;
          end else if (acl_len != '0) begin
            remain_d = acl_len;
            phase_d  = PhAclData;
          end else begin
            res.eop = 1'b1;
            phase_d = PhIdle;
          end
        end
      end
      PhAclData: begin
        res.valid = 1'b1;
        res.kind  = KindAcl;
        remain_d  = remain_dec;
        if (remain_dec == '0) begin
          res.eop = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    if (res.valid) begin
      count_d = res.aborted ? '0 : count_q + CountW'(1);
    end
  end

  assign result_o = '{
    valid:   res.valid & step_i,
    data:    res.data,
    kind:    res.kind,
    index:   res.index,
    eop:     res.eop,
    aborted: res.aborted
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      count_q     <= '0;
      remain_q    <= '0;
      len_low_q   <= '0;
      high_next_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      len_low_q   <= len_low_d;
      high_next_q <= high_next_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_abort_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.aborted |=> phase_q == PhIdle)
    else $error("aborted packet did not return to idle");
  a_eop_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.eop |=> phase_q == PhIdle)
    else $error("completed packet did not return to idle");
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> !result_o.valid)
    else $error("result produced while idle");
`endif

endmodule

[hdl/hci_uart_packet_deframer.sv]
// Top level of the HCI UART H4 receive deframer with its APB register and pipeline stages.
//
// Channel   Direction  Handshake                Payload
// rx        in         in_valid_i / in_ready_o  rx_byte_i
// packet    out        out_valid_o / out_ready_i packet_byte_o, packet_kind_o, byte_index_o,
//                                               end_of_packet_o, packet_aborted_o
// cfg       in         psel/penable/pwrite      paddr, pwdata, prdata (pready always high)
//
// One byte is accepted every cycle while the output is not stalled; each result is registered.
// The input register feeds the phase tracker, whose combinational logic loads the result register.
// A stalled output holds the result register and the input register, then the input stalls.
// Bytes that produce no result retire without touching the output.
// Reset returns to the idle phase and sets the ACL length limit to 1020.
module hci_uart_packet_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hcidf_pkg::ByteW-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hcidf_pkg::ByteW-1:0]   packet_byte_o,
  output logic                          packet_kind_o,
  output logic [hcidf_pkg::CountW-1:0]  byte_index_o,
  output logic                          end_of_packet_o,
  output logic                          packet_aborted_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hcidf_pkg::AddrW-1:0]   paddr,
  input  logic [hcidf_pkg::DataW-1:0]   pwdata,
  output logic [hcidf_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import hcidf_pkg::*;

  logic [CountW-1:0] limit_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              advance;
  hcidf_result_t     result;
  hcidf_result_t     out_q;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1] == RegIdxAclLimit);
  assign prdata  = reg_sel ? DataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AclLimitReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_q <= pwdata[CountW-1:0];
    end
  end

  assign advance    = in_valid_q && (!out_q.valid || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  hcidf_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .limit_i  (limit_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (result.valid) begin
      out_q <= result;
    end else if (out_ready_i) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid_o      = out_q.valid;
  assign packet_byte_o    = out_q.data;
  assign packet_kind_o    = out_q.kind;
  assign byte_index_o     = out_q.index;
  assign end_of_packet_o  = out_q.eop;
  assign packet_aborted_o = out_q.aborted;

`ifndef NO_ASSERTIONS
  a_eop_abort_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(end_of_packet_o && packet_aborted_o))
    else $error("result marked both complete and aborted");
  a_abort_is_acl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_aborted_o |-> packet_kind_o == KindAcl)
    else $error("abort on a non-ACL packet");
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");
`endif

endmodule

[verif/hcidf_checker.sv]
// Checker that predicts and compares the deframed packet bytes of the HCI UART deframer.
module hcidf_checker
  import hcidf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ByteW-1:0]  packet_byte_i,
  input  logic              packet_kind_i,
  input  logic [CountW-1:0] byte_index_i,
  input  logic              end_of_packet_i,
  input  logic              packet_aborted_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [DataW-1:0]  pwdata_i,
  input  logic [DataW-1:0]  prdata_i,
  input  logic              pready_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              kind;
    logic [CountW-1:0] index;
    logic              eop;
    logic              aborted;
  } deframed_byte_t;

  localparam logic [AddrW-1:0] LimitAddr = AddrW'({RegIdxAclLimit, 2'b00});
  localparam int unsigned MaxReports = 20;

  rx_phase_e         phase;
  logic [CountW-1:0] next_index;
  logic [CountW-1:0] body_left;
  logic [CountW-1:0] acl_length;
  logic [CountW-1:0] acl_limit;
  logic              length_high_next;
  deframed_byte_t    expected_bytes[$];
  int unsigned       mismatches;
  int unsigned       checked;

  function automatic void queue_byte(logic [ByteW-1:0] b, logic pkt_kind, logic eop_flag,
                                     logic abort_flag);
    expected_bytes.push_back('{data: b, kind: pkt_kind, index: next_index, eop: eop_flag,
                               aborted: abort_flag});
    next_index = next_index + CountW'(1);
  endfunction

  function automatic void deframe_byte(logic [ByteW-1:0] b);
    case (phase)
      PhIdle: begin
        if (b == IndEvent) begin
          next_index = '0;
          phase = PhEvCode;
        end else if (b == IndAcl) begin
          next_index = '0;
          length_high_next = 1'b0;
          phase = PhAclHandle;
        end
      end
      PhEvCode: begin
        phase = PhEvLen;
        queue_byte(b, KindEvent, 1'b0, 1'b0);
      end
      PhEvLen: begin
        if (b != '0) begin
          body_left = CountW'(b);
          phase = PhEvParam;
          queue_byte(b, KindEvent, 1'b0, 1'b0);
        end else begin
          phase = PhIdle;
          queue_byte(b, KindEvent, 1'b1, 1'b0);
        end
      end
      PhEvParam, PhAclData: begin
        body_left = body_left - CountW'(1);
        if (body_left == '0) begin
          queue_byte(b, (phase == PhAclData) ? KindAcl : KindEvent, 1'b1, 1'b0);
          phase = PhIdle;
        end else begin
          queue_byte(b, (phase == PhAclData) ? KindAcl : KindEvent, 1'b0, 1'b0);
        end
      end
      PhAclHandle: begin
        if (next_index != '0) phase = PhAclLen;
        queue_byte(b, KindAcl, 1'b0, 1'b0);
      end
      PhAclLen: begin
        if (!length_high_next) begin
          acl_length = CountW'(b);
          length_high_next = 1'b1;
          queue_byte(b, KindAcl, 1'b0, 1'b0);
        end else begin
          length_high_next = 1'b0;
          acl_length = {b, acl_length[ByteW-1:0]};
          if (acl_length > acl_limit) begin
            phase = PhIdle;
            queue_byte(b, KindAcl, 1'b0, 1'b1);
            next_index = '0;
          end else if (acl_length != '0) begin
            body_left = acl_length;
            phase = PhAclData;
            queue_byte(b, KindAcl, 1'b0, 1'b0);
          end else begin
            phase = PhIdle;
            queue_byte(b, KindAcl, 1'b1, 1'b0);
          end
        end
      end
      default: phase = PhIdle;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReports) $display("%0t ns checker: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    deframed_byte_t got;
    deframed_byte_t want;
    if (!rst_ni) begin
      phase = PhIdle;
      next_index = '0;
      body_left = '0;
      acl_length = '0;
      length_high_next = 1'b0;
      acl_limit = AclLimitReset;
      expected_bytes.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == LimitAddr) begin
        if (pwrite_i) begin
          acl_limit = pwdata_i[CountW-1:0];
        end else if (prdata_i[CountW-1:0] !== acl_limit) begin
          report_mismatch($sformatf("limit read back %0d, expected %0d",
                                    prdata_i[CountW-1:0], acl_limit));
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{data: packet_byte_i, kind: packet_kind_i, index: byte_index_i,
                eop: end_of_packet_i, aborted: packet_aborted_i};
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, byte %02h index %0d",
                                    got.data, got.index));
        end else begin
          want = expected_bytes.pop_front();
          checked++;
          if (got !== want) begin
            report_mismatch($sformatf(
              "result %0d: expected byte %02h kind %0d index %0d end %0d abort %0d, got %s",
              checked, want.data, want.kind, want.index, want.eop, want.aborted,
              $sformatf("byte %02h kind %0d index %0d end %0d abort %0d", got.data, got.kind,
                        got.index, got.eop, got.aborted)));
          end
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(rx_byte_i);
    end
    mismatch_count_o <= mismatches;
    pending_o <= expected_bytes.size();
    checked_o <= checked;
  end

endmodule

[verif/hci_uart_packet_deframer_test.sv]
// Testbench top that drives H4 byte streams and limit settings into the HCI UART deframer.
module hci_uart_packet_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcidf_pkg::*;

  localparam logic [AddrW-1:0] LimitAddr = AddrW'({RegIdxAclLimit, 2'b00});
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 280;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct[4] = '{0, 52, 0, 19};
  localparam int unsigned StallPct[4] = '{0, 0, 52, 19};
  localparam logic [ByteW-1:0] DirectedBytes[26] = '{
    8'h00, 8'hFF,
    IndEvent, 8'hFF, 8'h00,
    IndEvent, 8'h00, 8'h01, 8'hAA,
    IndAcl, 8'h01, 8'h20, 8'h00, 8'h00,
    IndAcl, 8'hFF, 8'h0F, 8'hFD, 8'h03,
    IndAcl, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h55, 8'hAA
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ByteW-1:0]  rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ByteW-1:0]  packet_byte_o;
  logic              packet_kind_o;
  logic [CountW-1:0] byte_index_o;
  logic              end_of_packet_o;
  logic              packet_aborted_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int unsigned       mismatch_count;
  int unsigned       results_pending;
  int unsigned       results_checked;
  int unsigned       bytes_sent;
  int unsigned       sender_idle_pct;
  int unsigned       receiver_stall_pct;
  int unsigned       cycles;
  int unsigned       hold_left;
  bit                hold_request;
  logic [CountW-1:0] phase_limit[4];

  hci_uart_packet_deframer u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .packet_byte_o,
    .packet_kind_o,
    .byte_index_o,
    .end_of_packet_o,
    .packet_aborted_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  hcidf_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .rx_byte_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .packet_byte_i    (packet_byte_o),
    .packet_kind_i    (packet_kind_o),
    .byte_index_i     (byte_index_o),
    .end_of_packet_i  (end_of_packet_o),
    .packet_aborted_i (packet_aborted_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending),
    .checked_o        (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timed out after %0d cycles with %0d results outstanding", cycles,
                 results_pending);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom);
    while (b == IndEvent || b == IndAcl) b = ByteW'($urandom);
    return b;
  endfunction

  function automatic int unsigned event_length();
    int unsigned r;
    r = $urandom_range(199);
    if (r < 20) return 0;
    if (r == 199) return 255;
    return $urandom_range(10, 1);
  endfunction

  function automatic int unsigned acl_length(input logic [CountW-1:0] lim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20 && lim < 16'hFFFF) return $urandom_range(65535, 32'(lim) + 1);
    if (r < 25 && lim <= 64) return 32'(lim);
    if (r < 30 && lim < 16'hFFFF) return 32'(lim) + 1;
    if (lim == 0) return 0;
    return $urandom_range((lim < 12) ? 32'(lim) : 12, 1);
  endfunction

  task automatic send_rx_byte(input logic [ByteW-1:0] b);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write_access, input logic [CountW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write_access;
    paddr <= LimitAddr;
    pwdata <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_event_packet(input int unsigned len);
    send_rx_byte(IndEvent);
    send_rx_byte(ByteW'($urandom));
    send_rx_byte(ByteW'(len));
    repeat (len) send_rx_byte(ByteW'($urandom));
  endtask

  task automatic send_acl_packet(input int unsigned len, input logic [CountW-1:0] lim);
    send_rx_byte(IndAcl);
    send_rx_byte(ByteW'($urandom));
    send_rx_byte(ByteW'($urandom));
    send_rx_byte(len[7:0]);
    send_rx_byte(len[15:8]);
    if (len > lim) begin
      repeat ($urandom_range(3)) send_rx_byte(noise_byte());
    end else begin
      repeat (len) send_rx_byte(ByteW'($urandom));
    end
  endtask

  task automatic send_random_traffic(input logic [CountW-1:0] lim);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_event_packet(event_length());
    end else if (pick < 80) begin
      send_acl_packet(acl_length(lim), lim);
    end else if (pick < 92) begin
      repeat ($urandom_range(3, 1)) send_rx_byte(noise_byte());
    end else begin
      repeat ($urandom_range(3, 1)) send_rx_byte(ByteW'($urandom));
    end
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned pause_at;
    bit paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 1'b0;
    bytes_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    paused = 1'b0;
    phase_limit[0] = AclLimitReset;
    phase_limit[1] = '0;
    phase_limit[2] = 16'd65531;
    phase_limit[3] = CountW'($urandom_range(40, 4));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, '0);
    foreach (DirectedBytes[i]) send_rx_byte(DirectedBytes[i]);

    for (int p = 0; p < 4; p++) begin
      wait_results_drained();
      apb_access(1'b1, phase_limit[p]);
      apb_access(1'b0, '0);
      sender_idle_pct = IdlePct[p];
      receiver_stall_pct = StallPct[p];
      if (p == 0) hold_request = 1'b1;
      phase_end = bytes_sent + PhaseItems;
      pause_at = bytes_sent + PhaseItems / 2;
      while (bytes_sent < phase_end) begin
        if (p == 1 && !paused && bytes_sent >= pause_at) begin
          wait_results_drained();
          paused = 1'b1;
        end
        send_random_traffic(phase_limit[p]);
      end
    end

    wait_results_drained();
    $display("Drove %0d received bytes of event, ACL and noise traffic over four pacing phases,",
             bytes_sent);
    $display("checking %0d packet bytes under length limits 1020, 0, 65531 and %0d.",
             results_checked, phase_limit[3]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[hci_uart_packet_deframer.f]
hdl/hcidf_pkg.sv
hdl/hcidf_parser.sv
hdl/hci_uart_packet_deframer.sv
verif/hcidf_checker.sv
verif/hci_uart_packet_deframer_test.sv
